[hdl/swap_victim_selector_assert.svh]
// Assertion macros for the swap victim selector.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SWAP_VICTIM_SELECTOR_ASSERT_SVH
`define SWAP_VICTIM_SELECTOR_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SVS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SVS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/svs_pkg.sv]
// Shared constants and types of the swap victim selector.
// No dependencies; imported by svs_cell and swap_victim_selector.
package svs_pkg;

   localparam int SLOTS   = 16;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int SIZE_W  = 12;
   localparam int PRIO_W  = 3;
   localparam int STAMP_W = 32;
   localparam int UNITS_W = 16;
   localparam int COUNT_W = 5;

   localparam logic [UNITS_W-1:0] CAPACITY_RESET = 16'd1024;

   localparam logic [1:0] POLICY_LOAD   = 2'd0;
   localparam logic [1:0] POLICY_ACCESS = 2'd1;

   localparam logic CSR_POLICY   = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic               live;
      logic               found;
      logic [STAMP_W-1:0] key;
      logic [IDX_W-1:0]   index;
      logic [SIZE_W-1:0]  size;
   } token_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic               touch;
      logic               load;
      logic               evict;
      logic [IDX_W-1:0]   index;
      logic [SIZE_W-1:0]  size;
      logic [PRIO_W-1:0]  prio;
      logic [STAMP_W-1:0] tick;
      logic [1:0]         policy;
   } cmd_type;

endpackage

[hdl/svs_cell.sv]
// One process slot of the victim search chain.
// Depends on svs_pkg for the token and command types.
module svs_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [svs_pkg::IDX_W-1:0]   cell_index,
   input  svs_pkg::cmd_type            cmd,
   input  svs_pkg::token_type          token_in,
   output svs_pkg::token_type          token_out,
   output logic                        resident
);
   import svs_pkg::*;

   logic               res_ff, res_in;
   logic [SIZE_W-1:0]  size_ff;
   logic [PRIO_W-1:0]  prio_ff;
   logic [STAMP_W-1:0] load_ff, acc_ff;
   token_type          token_ff, token_in_next;
   logic               sel;
   logic [STAMP_W-1:0] key;
   logic               better;

   assign sel = (cmd.index == cell_index);

   always_comb begin
      res_in = res_ff;
      if (sel && cmd.load) begin
         res_in = 1'b1;
      end else if (sel && cmd.evict) begin
         res_in = 1'b0;
      end
   end

   // Stamps are compared by age so that a wrapped tick keeps the order.
   always_comb begin
      if (cmd.policy == POLICY_LOAD) begin
         key    = cmd.tick - load_ff;
         better = (key >= token_in.key);
      end else if (cmd.policy == POLICY_ACCESS) begin
         key    = cmd.tick - acc_ff;
         better = (key >= token_in.key);
      end else begin
         key    = STAMP_W'(prio_ff);
         better = (key < token_in.key);
      end
   end

   always_comb begin
      token_in_next = token_in;
      if (token_in.live && res_ff && (!token_in.found || better)) begin
         token_in_next.found = 1'b1;
         token_in_next.key   = key;
         token_in_next.index = cell_index;
         token_in_next.size  = size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff        <= 1'b0;
         token_ff.live <= 1'b0;
      end else begin
         res_ff   <= res_in;
         token_ff <= token_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && cmd.load) begin
         size_ff <= cmd.size;
         prio_ff <= cmd.prio;
         load_ff <= cmd.tick;
      end
      if (sel && (cmd.load || cmd.touch)) begin
         acc_ff <= cmd.tick;
      end
   end

   assign token_out = token_ff;
   assign resident  = res_ff;

endmodule

[hdl/swap_victim_selector.sv]
// Top level of the swap victim selector: controller, counters and the cell chain.
// Depends on svs_pkg, svs_cell and swap_victim_selector_assert.svh.
//
//   Channel  Direction  Contents
//   req_     in         process index, size and priority of one access
//   rsp_     out        outcome, eviction mask and count, usage and totals
//   csr_     in         register writes: policy (index 0), capacity (index 1)
//
// A hit or a rejected access goes from the check state to the finish state.
// A miss goes to the swap-in state, first passing the search state for every
// eviction; each eviction is one token pass along the chain of cells.
// Reset is synchronous and clears residency, usage, the tick and the totals.
// A result held by a stalled rsp_ channel holds the controller in its final
// state; no new request transfer is taken until the controller is idle.
`include "swap_victim_selector_assert.svh"

module swap_victim_selector (
   input  logic        clock,
   input  logic        reset,
   // req_tdata fields from bit 0: process_index[3:0], process_size[15:4],
   // process_priority[18:16], zero pad[23:19]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // rsp_tdata fields from bit 0: hit[0], swapped_in[1], rejected[2],
   // evicted_mask[18:3], evicted_count[23:19], memory_in_use[39:24],
   // total_swap_ins[55:40], total_swap_outs[71:56]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import svs_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_SWAPIN = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [1:0]         pol_ff;
   logic [UNITS_W-1:0] cap_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [PRIO_W-1:0]  prio_ff, prio_in;
   logic [UNITS_W-1:0] used_ff, used_in;
   logic [STAMP_W-1:0] tick_ff, tick_in;
   logic [UNITS_W-1:0] ins_ff, ins_in, outs_ff, outs_in;
   logic               hit_ff, hit_in, swp_ff, swp_in, rej_ff, rej_in;
   logic [15:0]        mask_ff, mask_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [71:0]        rsp_data_ff, rsp_data_in;

   cmd_type            cmd;
   token_type          chain [0:SLOTS];
   logic [SLOTS-1:0]   res_vec;
   token_type          tail;
   logic               req_xfer;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign tail       = chain[SLOTS];

   // Chain of slot cells; a fresh token enters cell 0 when a search starts.
   always_comb begin
      chain[0]       = '0;
      chain[0].live  = (state_ff == ST_CHECK) && !rej_in && !hit_in
                       && (state_in == ST_SEARCH);
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      svs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(g)),
         .cmd        (cmd),
         .token_in   (chain[g]),
         .token_out  (chain[g+1]),
         .resident   (res_vec[g])
      );
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      size_in      = size_ff;
      prio_in      = prio_ff;
      used_in      = used_ff;
      tick_in      = tick_ff;
      ins_in       = ins_ff;
      outs_in      = outs_ff;
      hit_in       = hit_ff;
      swp_in       = swp_ff;
      rej_in       = rej_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd          = '0;
      cmd.index    = idx_ff;
      cmd.size     = size_ff;
      cmd.prio     = prio_ff;
      cmd.tick     = tick_ff;
      cmd.policy   = pol_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               idx_in   = req_tdata[3:0];
               size_in  = req_tdata[15:4];
               prio_in  = req_tdata[18:16];
               hit_in   = 1'b0;
               swp_in   = 1'b0;
               rej_in   = 1'b0;
               mask_in  = '0;
               cnt_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (32'(idx_ff) >= SLOTS) begin
               rej_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (res_vec[idx_ff]) begin
               // A hit only refreshes the access stamp.
               cmd.touch = 1'b1;
               hit_in    = 1'b1;
               state_in  = ST_FINISH;
            end else if (UNITS_W'(size_ff) > cap_ff) begin
               rej_in   = 1'b1;
               state_in = ST_FINISH;
            end else if (({1'b0, used_ff} + (UNITS_W+1)'(size_ff)) > {1'b0, cap_ff}) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_SWAPIN;
            end
         end
         ST_SEARCH: begin
            if (tail.live) begin
               if (tail.found) begin
                  cmd.evict = 1'b1;
                  cmd.index = tail.index;
                  used_in   = used_ff - UNITS_W'(tail.size);
                  mask_in[tail.index] = 1'b1;
                  if (cnt_ff != '1) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
                  if (outs_ff != '1) begin
                     outs_in = outs_ff + 1'b1;
                  end
                  state_in = ST_CHECK;
               end else begin
                  // Nothing left to evict: the process fits regardless.
                  state_in = ST_SWAPIN;
               end
            end
         end
         ST_SWAPIN: begin
            cmd.load = 1'b1;
            used_in  = used_ff + UNITS_W'(size_ff);
            swp_in   = 1'b1;
            if (ins_ff != '1) begin
               ins_in = ins_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {outs_ff, ins_ff, used_ff, cnt_ff, mask_ff,
                               rej_ff, swp_ff, hit_ff};
               tick_in      = tick_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pol_ff       <= POLICY_LOAD;
         cap_ff       <= CAPACITY_RESET;
         used_ff      <= '0;
         tick_ff      <= '0;
         ins_ff       <= '0;
         outs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         tick_ff      <= tick_in;
         ins_ff       <= ins_in;
         outs_ff      <= outs_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_POLICY:   pol_ff <= csr_data[1:0];
               CSR_CAPACITY: cap_ff <= csr_data;
               default:      pol_ff <= pol_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      size_ff     <= size_in;
      prio_ff     <= prio_in;
      hit_ff      <= hit_in;
      swp_ff      <= swp_in;
      rej_ff      <= rej_in;
      mask_ff     <= mask_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SVS_ASSERT_NXT(a_evict_counts, (state_ff == ST_SEARCH) && tail.live && tail.found, cnt_ff == $past(cnt_ff) + 1'b1)
   `SVS_ASSERT_NXT(a_load_resident, state_ff == ST_SWAPIN, res_vec[$past(idx_ff)])
   `SVS_ASSERT_IMP(a_swapin_fits, (state_ff == ST_FINISH) && swp_ff, used_ff <= cap_ff)

endmodule

[dv/swap_victim_selector_checker.sv]
// Checker of the swap victim selector: keeps its own slot table, predicts the
// outcome of every access and compares it with the rsp_ channel.
// Depends on svs_pkg only.
`timescale 1ns / 100ps

module swap_victim_selector_checker
   import svs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output int          failures,
   output int          pending
);

   typedef struct packed {
      logic               hit;
      logic               swapped_in;
      logic               rejected;
      logic [15:0]        evicted_mask;
      logic [COUNT_W-1:0] evicted_count;
      logic [UNITS_W-1:0] memory_in_use;
      logic [15:0]        total_swap_ins;
      logic [15:0]        total_swap_outs;
   } outcome_type;

   logic               resident [SLOTS];
   logic [SIZE_W-1:0]  held_size [SLOTS];
   logic [PRIO_W-1:0]  held_prio [SLOTS];
   logic [STAMP_W-1:0] loaded_at [SLOTS];
   logic [STAMP_W-1:0] touched_at [SLOTS];
   int unsigned        units_used;
   logic [STAMP_W-1:0] now_tick;
   logic [15:0]        ins_total;
   logic [15:0]        outs_total;
   logic [1:0]         rule;
   logic [UNITS_W-1:0] mem_limit;

   outcome_type expected_outcomes [$];

   assign pending = expected_outcomes.size();

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      failures++;
   endtask

   // Victim under the current rule, or -1 when nothing is resident.
   function automatic int choose_victim();
      int                 victim;
      logic [STAMP_W-1:0] age;
      logic [STAMP_W-1:0] oldest;
      logic [PRIO_W-1:0]  lowest;
      victim = -1;
      oldest = '0;
      lowest = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (resident[i]) begin
            if (rule == POLICY_LOAD || rule == POLICY_ACCESS) begin
               age = now_tick - ((rule == POLICY_LOAD) ? loaded_at[i] : touched_at[i]);
               if (victim < 0 || age >= oldest) begin
                  oldest = age;
                  victim = i;
               end
            end else if (victim < 0 || held_prio[i] < lowest) begin
               lowest = held_prio[i];
               victim = i;
            end
         end
      end
      return victim;
   endfunction

   function automatic outcome_type predict_access(input logic [23:0] data);
      outcome_type        res;
      logic [IDX_W-1:0]   slot;
      logic [SIZE_W-1:0]  units;
      logic [PRIO_W-1:0]  prio;
      int                 victim;
      slot  = data[3:0];
      units = data[15:4];
      prio  = data[18:16];
      res   = '0;
      if (resident[slot]) begin
         res.hit = 1'b1;
         touched_at[slot] = now_tick;
      end else if (units > mem_limit) begin
         res.rejected = 1'b1;
      end else begin
         while (units_used + units > mem_limit) begin
            victim = choose_victim();
            if (victim < 0) break;
            resident[victim] = 1'b0;
            units_used -= held_size[victim];
            res.evicted_mask[victim] = 1'b1;
            if (res.evicted_count < 31) res.evicted_count++;
            if (outs_total != 16'hFFFF) outs_total++;
         end
         resident[slot]   = 1'b1;
         held_size[slot]  = units;
         held_prio[slot]  = prio;
         loaded_at[slot]  = now_tick;
         touched_at[slot] = now_tick;
         units_used += units;
         res.swapped_in = 1'b1;
         if (ins_total != 16'hFFFF) ins_total++;
      end
      now_tick++;
      res.memory_in_use   = units_used[UNITS_W-1:0];
      res.total_swap_ins  = ins_total;
      res.total_swap_outs = outs_total;
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         foreach (resident[i]) resident[i] = 1'b0;
         units_used = 0;
         now_tick   = '0;
         ins_total  = '0;
         outs_total = '0;
         rule       = POLICY_LOAD;
         mem_limit  = CAPACITY_RESET;
         failures   = 0;
         expected_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POLICY) rule = csr_data[1:0];
            else mem_limit = csr_data;
         end
         if (req_tvalid && req_tready) expected_outcomes.push_back(predict_access(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[71:56], rsp_tdata[55:40], rsp_tdata[39:24], rsp_tdata[23:19],
                   rsp_tdata[18:3], rsp_tdata[2], rsp_tdata[1], rsp_tdata[0]};
            got = '{hit: rsp_tdata[0], swapped_in: rsp_tdata[1], rejected: rsp_tdata[2],
                    evicted_mask: rsp_tdata[18:3], evicted_count: rsp_tdata[23:19],
                    memory_in_use: rsp_tdata[39:24], total_swap_ins: rsp_tdata[55:40],
                    total_swap_outs: rsp_tdata[71:56]};
            if (expected_outcomes.size() == 0) begin
               $display("%0t result transfer with no access outstanding", $realtime);
               failures++;
            end else begin
               want = expected_outcomes.pop_front();
               if (got.hit != want.hit) report("hit", got.hit, want.hit);
               if (got.swapped_in != want.swapped_in)
                  report("swapped_in", got.swapped_in, want.swapped_in);
               if (got.rejected != want.rejected) report("rejected", got.rejected, want.rejected);
               if (got.evicted_mask != want.evicted_mask)
                  report("evicted_mask", got.evicted_mask, want.evicted_mask);
               if (got.evicted_count != want.evicted_count)
                  report("evicted_count", got.evicted_count, want.evicted_count);
               if (got.memory_in_use != want.memory_in_use)
                  report("memory_in_use", got.memory_in_use, want.memory_in_use);
               if (got.total_swap_ins != want.total_swap_ins)
                  report("total_swap_ins", got.total_swap_ins, want.total_swap_ins);
               if (got.total_swap_outs != want.total_swap_outs)
                  report("total_swap_outs", got.total_swap_outs, want.total_swap_outs);
            end
         end
      end
   end

endmodule

[dv/swap_victim_selector_tb.sv]
// Top of the swap victim selector testbench: clock, reset, access stimulus,
// register writes and the verdict. Depends on svs_pkg, the block and its checker.
`timescale 1ns / 100ps

module swap_victim_selector_tb;
   import svs_pkg::*;

   // Lowest-priority rule and its undocumented alias, which has to behave the same.
   localparam logic [1:0] POLICY_PRIORITY = 2'd2;
   localparam logic [1:0] POLICY_SPARE    = 2'd3;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // fields from bit 0: process_index[3:0], process_size[15:4],
   // process_priority[18:16], zero pad[23:19]
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // fields from bit 0: hit, swapped_in, rejected, evicted_mask, evicted_count,
   // memory_in_use, total_swap_ins, total_swap_outs
   logic [71:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_data;
   int          failures;
   int          pending;

   // Shared between the stimulus and the receiver: random idling on or off,
   // and a request for one long hold-off on the result side.
   bit idling_on;
   bit hold_wanted;
   int idle_cycles;
   int unsigned mem_limit_now;

   swap_victim_selector i_dut (.*);

   swap_victim_selector_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random back-pressure, plus one long hold-off counted here so
   // that the block holds its result and stops taking accesses while the sender waits.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idling_on && $urandom_range(99) < 8);
         end
      end
   end

   // Watchdog: any transfer on any channel restarts the count.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offers one access and returns on the edge of its transfer. tvalid is left
   // high so that back-to-back accesses need no second assignment in a step.
   task automatic send_access(input int slot, input int units, input int prio);
      if (idling_on && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, prio[2:0], units[11:0], slot[3:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   // Register writes only with the block empty: drop tvalid, let every result
   // come back, give the controller time to settle, then write.
   task automatic write_reg(input logic index, input int value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value[15:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_CAPACITY) mem_limit_now = value;
   endtask

   // Mostly accesses scaled to the capacity so that misses evict a few
   // victims and slots get reused; the rest are tiny fills, fills as big as the
   // capacity, and fully random fields.
   task automatic random_access();
      int pick;
      int top;
      pick = $urandom_range(99);
      top  = (mem_limit_now / 3 > 4095) ? 4095 : mem_limit_now / 3;
      if (pick < 65)
         send_access($urandom_range(15), $urandom_range(top + 1, 1), $urandom_range(7));
      else if (pick < 80)
         send_access($urandom_range(15), $urandom_range(16), $urandom_range(7));
      else if (pick < 88)
         send_access($urandom_range(15),
                     (mem_limit_now > 4095) ? 4095 : mem_limit_now, $urandom_range(7));
      else
         send_access($urandom_range(15), $urandom_range(4095), $urandom_range(7));
   endtask

   initial begin
      logic [1:0] rules [8];
      int         limits [8];
      rules  = '{POLICY_ACCESS, POLICY_PRIORITY, POLICY_SPARE, POLICY_LOAD,
                 POLICY_ACCESS, POLICY_PRIORITY, POLICY_LOAD, POLICY_PRIORITY};
      limits = '{1024, 2048, 700, 65535, 4095, 0, 300, 200};
      idling_on     = 1'b1;
      hold_wanted   = 1'b0;
      mem_limit_now = CAPACITY_RESET;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_POLICY;
      csr_data   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings (oldest loaded, 1024 units).
      send_access(0, 0, 0);        // zero-sized process
      send_access(15, 4095, 7);    // larger than the capacity: rejected
      send_access(1, 1024, 7);     // exact fit alongside the empty slot
      send_access(1, 5, 3);        // hit, size and priority ignored
      send_access(2, 1, 0);        // evicts both, oldest load first
      send_access(3, 1023, 4);     // fills memory exactly
      send_access(2, 7, 1);        // hit refreshes the access stamp only
      send_access(4, 2, 5);        // evicts slot 2, the oldest load, then slot 3
      write_reg(CSR_POLICY, POLICY_ACCESS);
      for (int i = 5; i < 9; i++) send_access(i, 200, i - 5);
      send_access(5, 1, 0);        // refresh, so slots 4 and 6 are least recent
      send_access(9, 900, 6);      // several evictions by access age
      write_reg(CSR_POLICY, POLICY_PRIORITY);
      for (int i = 10; i < 14; i++) send_access(i, 250, 7 - (i % 2) * 7);
      send_access(14, 1000, 2);    // lowest priority, lowest index first
      write_reg(CSR_POLICY, POLICY_SPARE);
      send_access(15, 1024, 3);    // whole memory: everything goes
      send_access(0, 4095, 7);

      // Random phases through the settings; the capacity drops below the
      // usage more than once, which hits must leave as it is.
      foreach (rules[p]) begin
         write_reg(CSR_POLICY, rules[p]);
         write_reg(CSR_CAPACITY, limits[p]);
         idling_on = (p != 3);
         if (p == 1) hold_wanted = 1'b1;
         repeat (130) random_access();
      end
      req_tvalid <= 1'b0;
      idling_on = 1'b1;

      // One edge first, so that the last access is already counted as pending.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
